>>> rtl/core/iptp_pkg.sv
`default_nettype none
package iptp_pkg;
    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_FAM = 2'd2;
    localparam int QDEPTH = 2;

    // one finished string handed from front to back
    typedef struct packed {
        logic [1:0]   status;
        logic [127:0] addr;
    } t_result;

    function automatic logic [4:0] hex_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return 5'(c[3:0] + 4'd9);
        return 5'd16;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/iptp_if.sv
`default_nettype none
interface iptp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] address_family;
    logic [7:0] text_char;
    modport source (output valid, address_family, text_char, input ready);
    modport sink (input valid, address_family, text_char, output ready);
endinterface

interface iptp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] address_high;
    logic [63:0] address_low;
    modport source (output valid, status, address_high, address_low, input ready);
    modport sink (input valid, status, address_high, address_low, output ready);
endinterface
`default_nettype wire

>>> rtl/core/iptp_front.sv
`default_nettype none
module iptp_front import iptp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_fam,
    input  wire logic [7:0] i_char,
    output t_result         o_res,
    output logic            o_res_valid
);
    logic [15:0] r_grp [8];
    logic [3:0]  r_gcnt, r_gidx;
    logic        r_gap, r_dok, r_tail, r_colp, r_fail, r_start;
    logic [15:0] r_hex;
    logic [2:0]  r_hdig, r_ocnt;
    logic [7:0]  r_dec;
    logic [1:0]  r_ddig, r_fam;
    logic [7:0]  r_oct [4];

    logic [15:0] n_grp [8];
    logic [3:0]  n_gcnt, n_gidx;
    logic        n_gap, n_dok, n_tail, n_colp, n_fail;
    logic [15:0] n_hex;
    logic [2:0]  n_hdig, n_ocnt;
    logic [7:0]  n_dec;
    logic [1:0]  n_ddig;
    logic [7:0]  n_oct [4];
    t_result     n_res;

    logic [1:0]  fam;
    logic        is_dec, ok, dok_tmp;
    logic [4:0]  h;
    logic [9:0]  dv;
    logic [3:0]  lim;
    logic [15:0] g [8];
    logic [2:0]  d;

    assign fam = r_start ? i_fam : r_fam;
    assign is_dec = i_char >= 8'h30 && i_char <= 8'h39;
    assign h = hex_of(i_char);
    assign lim = r_gap ? 4'd7 : 4'd8;

    // per-character decode and end-of-string finish
    always_comb begin
        n_grp = r_grp; n_gcnt = r_gcnt; n_gidx = r_gidx; n_gap = r_gap;
        n_dok = r_dok; n_tail = r_tail; n_colp = r_colp; n_fail = r_fail;
        n_hex = r_hex; n_hdig = r_hdig; n_ocnt = r_ocnt; n_dec = r_dec;
        n_ddig = r_ddig; n_oct = r_oct;
        n_res = '{status: ST_BAD, addr: '0};
        ok = 1'b1; dok_tmp = 1'b0;
        g = '{default: 16'd0};
        dv = 10'({r_dec, 1'b0} + {r_dec, 3'b0} + 10'(i_char[3:0]));
        d = '0;
        if (i_char != 8'd0) begin
            if (!r_fail && fam < 2'd2) begin
                if (fam == FAM_V4 || r_tail) begin
                    if (is_dec) begin
                        if (r_ddig >= 2'd3 || dv > 10'd255) ok = 1'b0;
                        else begin n_dec = dv[7:0]; n_ddig = r_ddig + 2'd1; end
                    end else if (i_char == 8'h2e) begin
                        if (r_ddig == 2'd0 || r_ocnt >= 3'd3) ok = 1'b0;
                        else begin
                            n_oct[r_ocnt[1:0]] = r_dec; n_ocnt = r_ocnt + 3'd1;
                            n_dec = '0; n_ddig = '0;
                        end
                    end else ok = 1'b0;
                end else if (h < 5'd16) begin
                    n_dec = r_dec; n_ddig = r_ddig; n_dok = r_dok;
                    if (r_colp && r_gcnt == 4'd0 && !r_gap) ok = 1'b0;
                    else if (r_hdig == 3'd0 && r_gcnt >= lim) ok = 1'b0;
                    else if (r_hdig >= 3'd4) ok = 1'b0;
                    else begin
                        if (r_hdig == 3'd0) begin
                            n_dec = '0; n_ddig = '0; n_dok = 1'b1;
                            dv = 10'(i_char[3:0]);
                        end
                        n_hex = {r_hex[11:0], h[3:0]};
                        n_hdig = r_hdig + 3'd1;
                        n_colp = 1'b0;
                        if (n_dok) begin
                            dok_tmp = is_dec && n_ddig < 2'd3 && dv <= 10'd255;
                            if (dok_tmp) begin n_dec = dv[7:0]; n_ddig = n_ddig + 2'd1; end
                            else n_dok = 1'b0;
                        end
                    end
                end else if (i_char == 8'h3a) begin
                    if (r_hdig > 3'd0) begin
                        n_grp[r_gcnt[2:0]] = r_hex; n_gcnt = r_gcnt + 4'd1;
                        n_hex = '0; n_hdig = '0; n_colp = 1'b1;
                    end else if (r_colp) begin
                        if (r_gap || r_gcnt >= 4'd8) ok = 1'b0;
                        else begin n_gap = 1'b1; n_gidx = r_gcnt; n_colp = 1'b0; end
                    end else if (r_gcnt == 4'd0 && !r_gap) n_colp = 1'b1;
                    else ok = 1'b0;
                end else if (i_char == 8'h2e) begin
                    if (r_hdig == 3'd0 || !r_dok || r_gcnt + 4'd2 > lim) ok = 1'b0;
                    else begin
                        n_oct[0] = r_dec; n_ocnt = 3'd1; n_dec = '0; n_ddig = '0;
                        n_hex = '0; n_hdig = '0; n_tail = 1'b1;
                    end
                end else ok = 1'b0;
                if (!ok) n_fail = 1'b1;
            end
        end else begin
            if (fam >= 2'd2) n_res.status = ST_FAM;
            else if (!r_fail && fam == FAM_V4) begin
                if (r_ddig != 2'd0 && r_ocnt == 3'd3)
                    n_res = '{status: ST_OK,
                              addr: {96'd0, r_oct[0], r_oct[1], r_oct[2], r_dec}};
            end else if (!r_fail) begin
                ok = 1'b1;
                if (r_tail) begin
                    if (r_ddig == 2'd0 || r_ocnt != 3'd3) ok = 1'b0;
                    else begin
                        n_grp[r_gcnt[2:0]] = {r_oct[0], r_oct[1]};
                        n_grp[3'(r_gcnt + 4'd1)] = {r_oct[2], r_dec};
                        n_gcnt = r_gcnt + 4'd2;
                    end
                end else if (r_colp) ok = 1'b0;
                else if (r_hdig > 3'd0) begin
                    n_grp[r_gcnt[2:0]] = r_hex; n_gcnt = r_gcnt + 4'd1;
                end
                if (r_gap ? n_gcnt > 4'd7 : n_gcnt != 4'd8) ok = 1'b0;
                if (ok) begin
                    // place groups around the gap
                    for (int i = 0; i < 8; i++) begin
                        if (!r_gap) g[i] = n_grp[i];
                        else if (4'(i) < n_gcnt) begin
                            d = (4'(i) < r_gidx) ? 3'(i) : 3'(4'(i) + 4'd8 - n_gcnt);
                            g[d] = n_grp[i];
                        end
                    end
                    n_res = '{status: ST_OK,
                              addr: {g[0], g[1], g[2], g[3], g[4], g[5], g[6], g[7]}};
                end
            end
        end
    end

    // state update; cleared at string end
    always_ff @(posedge i_clk) begin
        o_res <= n_res;
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= i_valid && i_char == 8'd0;
        end
        if (!i_rst_n || (i_valid && i_char == 8'd0)) begin
            r_grp <= '{default: 16'd0}; r_oct <= '{default: 8'd0};
            r_gcnt <= '0; r_gidx <= '0; r_gap <= 1'b0; r_dok <= 1'b1;
            r_tail <= 1'b0; r_colp <= 1'b0; r_fail <= 1'b0; r_start <= 1'b1;
            r_hex <= '0; r_hdig <= '0; r_ocnt <= '0; r_dec <= '0; r_ddig <= '0;
            r_fam <= '0;
        end else if (i_valid) begin
            r_grp <= n_grp; r_oct <= n_oct; r_gcnt <= n_gcnt; r_gidx <= n_gidx;
            r_gap <= n_gap; r_dok <= n_dok; r_tail <= n_tail; r_colp <= n_colp;
            r_fail <= n_fail; r_start <= 1'b0; r_hex <= n_hex; r_hdig <= n_hdig;
            r_ocnt <= n_ocnt; r_dec <= n_dec; r_ddig <= n_ddig; r_fam <= fam;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/iptp_back.sv
`default_nettype none
module iptp_back import iptp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_room,
    iptp_out_if.source   o_out
);
    t_result    r_q [QDEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop = o_out.valid && o_out.ready;
    assign o_out.valid = r_cnt != 2'd0;
    assign o_out.status = r_q[r_rp].status;
    assign o_out.address_high = r_q[r_rp].addr[127:64];
    assign o_out.address_low = r_q[r_rp].addr[63:0];
    // one slot is kept for a result already in flight from the front
    assign o_room = r_cnt == 2'd0 || (r_cnt == 2'd1 && !i_push);

    // result queue
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_res;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !pop && r_cnt == 2'd2)) else $error("queue overflow");
    hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready && !i_push |=> o_out.valid)
        else $error("result lost");
    cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
endmodule
`default_nettype wire

>>> rtl/core/ip_address_text_parser_top.sv
`default_nettype none
// result: registered in the front at the zero byte, then queued in the back
// throughput: one character per cycle; input is held while the two-entry result
//   queue is full, or holds one result with another one on its way from the front
// reset: synchronous active low, clears parser state and empties the queue
module ip_address_text_parser_top import iptp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iptp_in_if.sink    i_in,
    iptp_out_if.source o_out
);
    t_result res;
    logic    res_valid, room, acc;

    assign i_in.ready = room;
    assign acc = i_in.valid && i_in.ready;

    iptp_front u_front (
        .i_clk, .i_rst_n, .i_valid(acc), .i_fam(i_in.address_family),
        .i_char(i_in.text_char), .o_res(res), .o_res_valid(res_valid)
    );

    iptp_back u_back (
        .i_clk, .i_rst_n, .i_push(res_valid), .i_res(res), .o_room(room), .o_out
    );
endmodule
`default_nettype wire

>>> dv/ip_address_text_parser_checker.sv
`timescale 1ns / 1ps
module ip_address_text_parser_checker import iptp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_ready,
    input  wire logic [1:0] i_in_family,
    input  wire logic [7:0] i_in_char,
    input  wire logic i_out_valid,
    input  wire logic i_out_ready,
    input  wire logic [1:0] i_out_status,
    input  wire logic [63:0] i_out_high,
    input  wire logic [63:0] i_out_low,
    output int o_fail_count,
    output int o_pending
);
    typedef struct {
        logic [1:0]  status;
        logic [63:0] high;
        logic [63:0] low;
    } t_addr_result;

    t_addr_result parsed_q[$];

    // parser shadow state
    logic [15:0] grp[8];
    int unsigned grp_n, gap_at, hexv, hexd, decv, decd, oct_n;
    logic [7:0] oct[4];
    bit gap, dec_good, tail, colon_wait, bad, start;
    logic [1:0] fam;

    function automatic int unsigned hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic clear_parser();
        for (int i = 0; i < 8; i++) grp[i] = '0;
        for (int i = 0; i < 4; i++) oct[i] = '0;
        grp_n = 0; gap = 0; gap_at = 0; hexv = 0; hexd = 0;
        decv = 0; decd = 0; dec_good = 1; oct_n = 0; tail = 0;
        colon_wait = 0; bad = 0; start = 1; fam = FAM_V4;
    endtask

    function automatic bit push_digit(int unsigned d);
        int unsigned v;
        if (decd >= 3) return 0;
        v = decv * 10 + d;
        if (v > 255) return 0;
        decv = v; decd++;
        return 1;
    endfunction

    function automatic bit push_dot();
        if (decd == 0 || oct_n >= 3) return 0;
        oct[oct_n[1:0]] = decv[7:0];
        oct_n++; decv = 0; decd = 0;
        return 1;
    endfunction

    function automatic bit close_v4();
        if (decd == 0 || oct_n != 3) return 0;
        oct[3] = decv[7:0]; oct_n = 4;
        return 1;
    endfunction

    function automatic void add_group(logic [15:0] v);
        grp[grp_n[2:0]] = v; grp_n++;
    endfunction

    function automatic bit v6_take(logic [7:0] c);
        int unsigned h, lim;
        lim = gap ? 7 : 8;
        if (tail) begin
            if (is_digit(c)) return push_digit(c - "0");
            if (c == ".") return push_dot();
            return 0;
        end
        h = hex_digit(c);
        if (h < 16) begin
            if (colon_wait && grp_n == 0 && !gap) return 0;
            if (hexd == 0) begin
                if (grp_n >= lim) return 0;
                decv = 0; decd = 0; dec_good = 1;
            end
            if (hexd >= 4) return 0;
            hexv = ((hexv << 4) | h) & 16'hFFFF;
            hexd++; colon_wait = 0;
            if (dec_good && !(is_digit(c) && push_digit(c - "0"))) dec_good = 0;
            return 1;
        end
        if (c == ":") begin
            if (hexd > 0) begin
                add_group(hexv[15:0]); hexv = 0; hexd = 0; colon_wait = 1;
                return 1;
            end
            if (colon_wait) begin
                if (gap || grp_n >= 8) return 0;
                gap = 1; gap_at = grp_n; colon_wait = 0;
                return 1;
            end
            if (grp_n == 0 && !gap) begin
                colon_wait = 1;
                return 1;
            end
            return 0;
        end
        if (c == ".") begin
            if (hexd == 0 || !dec_good) return 0;
            if (grp_n + 2 > lim) return 0;
            oct[0] = decv[7:0]; oct_n = 1; decv = 0; decd = 0;
            hexv = 0; hexd = 0; tail = 1;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit close_v6();
        if (tail) begin
            if (!close_v4()) return 0;
            add_group({oct[0], oct[1]});
            add_group({oct[2], oct[3]});
        end else begin
            if (colon_wait) return 0;
            if (hexd > 0) add_group(hexv[15:0]);
        end
        if (gap) return grp_n <= 7;
        return grp_n == 8;
    endfunction

    // advance shadow parser by one accepted character beat
    task automatic parse_char(logic [1:0] f, logic [7:0] c);
        t_addr_result r;
        logic [15:0] g[8];
        bit ok;
        int unsigned zeros, d;
        if (start) begin
            fam = f; start = 0;
        end
        if (c != 0) begin
            if (!bad && fam < 2) begin
                if (fam == FAM_V4) begin
                    if (is_digit(c)) ok = push_digit(c - "0");
                    else if (c == ".") ok = push_dot();
                    else ok = 0;
                end else ok = v6_take(c);
                if (!ok) bad = 1;
            end
            return;
        end
        r.status = ST_BAD; r.high = '0; r.low = '0;
        if (fam >= 2) r.status = ST_FAM;
        else if (!bad && fam == FAM_V4) begin
            if (close_v4()) begin
                r.status = ST_OK;
                r.low = {32'd0, oct[0], oct[1], oct[2], oct[3]};
            end
        end else if (!bad) begin
            if (close_v6()) begin
                for (int i = 0; i < 8; i++) g[i] = '0;
                if (gap) begin
                    zeros = 8 - grp_n;
                    for (int i = 0; i < grp_n; i++) begin
                        d = (i < gap_at) ? i : i + zeros;
                        g[d[2:0]] = grp[i];
                    end
                end else for (int i = 0; i < 8; i++) g[i] = grp[i];
                r.status = ST_OK;
                r.high = {g[0], g[1], g[2], g[3]};
                r.low = {g[4], g[5], g[6], g[7]};
            end
        end
        parsed_q.push_back(r);
        clear_parser();
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        t_addr_result e;
        if (!i_rst_n) begin
            clear_parser();
            parsed_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (parsed_q.size() == 0) begin
                    $error("unexpected result beat status %0d", i_out_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = parsed_q.pop_front();
                    if (e.status !== i_out_status || e.high !== i_out_high ||
                        e.low !== i_out_low) begin
                        if (e.status !== i_out_status)
                            $error("status exp %0d got %0d", e.status, i_out_status);
                        if (e.high !== i_out_high)
                            $error("address_high exp %h got %h", e.high, i_out_high);
                        if (e.low !== i_out_low)
                            $error("address_low exp %h got %h", e.low, i_out_low);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) parse_char(i_in_family, i_in_char);
        end
    end

    assign o_pending = parsed_q.size();
endmodule

>>> dv/ip_address_text_parser_top_tb.sv
`timescale 1ns / 1ps
module ip_address_text_parser_top_tb import iptp_pkg::*;;
    logic i_clk = 0;
    logic i_rst_n = 0;
    int fail_count, pending;

    iptp_in_if  in_ch ();
    iptp_out_if out_ch ();

    ip_address_text_parser_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    ip_address_text_parser_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_in_family(in_ch.address_family), .i_in_char(in_ch.text_char),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_out_status(out_ch.status), .i_out_high(out_ch.address_high),
        .i_out_low(out_ch.address_low),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0; in_ch.address_family = FAM_V4; in_ch.text_char = 0;
        out_ch.ready = 0;
    end

    // receiver stall pattern: alternating open and stalled stretches
    int stall_left = 0;
    bit stall_on = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_on <= ~stall_on;
            stall_left <= stall_on ? $urandom_range(1, 30) : $urandom_range(0, 6);
            out_ch.ready <= stall_on;
        end else stall_left <= stall_left - 1;
    end

    int burst_left = 0;
    int item_count = 0;

    // send one character beat, with bursty gaps
    task automatic send_char(logic [1:0] f, logic [7:0] c);
        if (burst_left == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(0, 4)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid <= 1;
        in_ch.address_family <= f;
        in_ch.text_char <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        item_count++;
    endtask

    // send a whole string, terminator included; family junk after first char
    task automatic send_text(logic [1:0] f, string s);
        for (int i = 0; i < s.len(); i++)
            send_char(i == 0 ? f : 2'($urandom_range(0, 3)), s[i]);
        send_char(s.len() == 0 ? f : 2'($urandom_range(0, 3)), 8'h00);
    endtask

    function automatic string rand_hex_group();
        string s = "";
        string digs = "0123456789abcdefABCDEF";
        int n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) s = {s, string'(digs[$urandom_range(0, 21)])};
        return s;
    endfunction

    function automatic string rand_v4();
        string s;
        s = $sformatf("%0d.%0d.%0d.%0d", $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) s = {"0", s};
        return s;
    endfunction

    function automatic string rand_v6();
        string s = "";
        int n, gap_pos, with_tail;
        with_tail = $urandom_range(0, 3) == 0;
        gap_pos = ($urandom_range(0, 1)) ? -1 : 0;
        n = with_tail ? 6 : 8;
        if (gap_pos == 0) begin
            n = $urandom_range(0, n - 1);
            gap_pos = $urandom_range(0, n);
        end
        for (int i = 0; i < n; i++) begin
            if (i == gap_pos) s = {s, "::"};
            else if (i > 0) s = {s, ":"};
            s = {s, rand_hex_group()};
        end
        if (gap_pos == n) s = {s, "::"};
        if (with_tail) begin
            if (n > 0 && gap_pos != n) s = {s, ":"};
            s = {s, rand_v4()};
        end
        return s;
    endfunction

    // damage a string by a single edit
    function automatic string corrupt(string s);
        int p;
        string junk = ":.0g9fZ /";
        if (s.len() == 0) return string'(junk[$urandom_range(0, 8)]);
        p = $urandom_range(0, s.len() - 1);
        case ($urandom_range(0, 2))
            0: s[p] = junk[$urandom_range(0, 8)];
            1: s = {s.substr(0, p), string'(junk[$urandom_range(0, 8)]),
                    s.substr(p + 1, s.len() - 1)};
            default: s = s.substr(0, p);
        endcase
        return s;
    endfunction

    // let the checker see the last beat before looking at its backlog
    task automatic wait_drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        string s, noise;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed strings
        send_text(FAM_V4, "0.0.0.0");
        send_text(FAM_V4, "255.255.255.255");
        send_text(FAM_V4, "256.1.1.1");
        send_text(FAM_V4, "010.001.1.0");
        send_text(FAM_V4, "1.2.3");
        send_text(FAM_V4, "");
        send_text(FAM_V6, "");
        send_text(2'd2, "1.2.3.4");
        send_text(2'd3, "");
        send_text(FAM_V6, "::");
        send_text(FAM_V6, "::1");
        send_text(FAM_V6, ":1::");
        send_text(FAM_V6, "1::");
        send_text(FAM_V6, "1:2:3:4:5:6:7:");
        send_text(FAM_V6, "ffff:FFFF:0:1:2:3:4:5");
        send_text(FAM_V6, "1:2:3:4:5:6:7:8:9");
        send_text(FAM_V6, "1:2:3:4:5:6:7:8x");
        send_text(FAM_V6, "1:2:3:4::5:6:7:8");
        send_text(FAM_V6, "1:::2");
        send_text(FAM_V6, "1::2::3");
        send_text(FAM_V6, "::ffff:192.168.0.1");
        send_text(FAM_V6, "1:2:3:4:5:6:1.2.3.4");
        send_text(FAM_V6, "a.1.2.3");
        send_text(FAM_V6, "12345::");
        wait_drain();

        // random strings, mostly well formed
        while (item_count < 950) begin
            k = $urandom_range(0, 19);
            if (k < 7) send_text(FAM_V4, rand_v4());
            else if (k < 14) send_text(FAM_V6, rand_v6());
            else if (k < 17) send_text(2'($urandom_range(0, 1)),
                                       corrupt($urandom_range(0, 1) ? rand_v4() : rand_v6()));
            else if (k < 18) send_text(2'($urandom_range(2, 3)), rand_v4());
            else begin
                noise = "";
                repeat ($urandom_range(0, 6))
                    noise = {noise, string'(8'($urandom_range(1, 255)))};
                send_text(2'($urandom_range(0, 3)), noise);
            end
        end
        wait_drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("ip_address_text_parser_top: match");
        else $display("ip_address_text_parser_top: mismatch");
        $finish;
    end

    initial begin
        #2ms;
        $display("ip_address_text_parser_top: mismatch");
        $finish;
    end
endmodule
